@@ src/fgti_pkg.sv @@
// ----------------------------------------------------------------------------
// fgti_pkg
// Shared types, constants and table lookups for the fuzzy gain table
// interpolator.
// ----------------------------------------------------------------------------
package fgti_pkg;

  localparam int COORD_FRAC_BITS_DEF = 12;

  localparam int IN_W        = 16;
  localparam int SEL_W       = 2;
  localparam int SCALE_W     = 16;
  localparam int RULE_W      = 48;
  localparam int RULE_LVL_W  = 3;
  localparam int N_TABLES    = 4;
  localparam int GAIN_TAB_W  = 63;
  localparam int GAIN_PT_W   = 9;
  localparam int GAIN_FRAC   = 6;
  localparam int OUT_FRAC    = 12;
  localparam int GAIN_W      = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 63;

  localparam logic [SCALE_W-1:0] DIST_SCALE_RST = 16'd4369;
  localparam logic [SCALE_W-1:0] ERR_SCALE_RST  = 16'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_SCALE  = 3'd0,
    CFG_ERR_SCALE   = 3'd1,
    CFG_RULE_ZERO   = 3'd2,
    CFG_RULE_ONE    = 3'd3,
    CFG_RULE_TWO    = 3'd4,
    CFG_RULE_THREE  = 3'd5,
    CFG_GAIN_LEFT   = 3'd6,
    CFG_GAIN_RIGHT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SCALE_W-1:0]                dist_scale;
    logic [SCALE_W-1:0]                err_scale;
    logic [N_TABLES-1:0][RULE_W-1:0]   rule_tab;
    logic [GAIN_TAB_W-1:0]             gain_left;
    logic [GAIN_TAB_W-1:0]             gain_right;
  } cfg_t;

  // Rule level at row r (distance), column c (error).
  function automatic logic [RULE_LVL_W-1:0] rule_at(input logic [RULE_W-1:0] tab,
                                                    input logic [1:0] r,
                                                    input logic [1:0] c);
    logic [5:0] pos;
    pos = 6'({r, c}) * 6'd3;
    return tab[pos +: RULE_LVL_W];
  endfunction

  // Gain point k of a seven entry table; code 7 wraps to entry 0.
  function automatic logic [GAIN_PT_W-1:0] gain_at(input logic [GAIN_TAB_W-1:0] tab,
                                                   input logic [2:0] k);
    logic [GAIN_PT_W-1:0] g;
    unique case (k)
      3'd1:    g = tab[9  +: GAIN_PT_W];
      3'd2:    g = tab[18 +: GAIN_PT_W];
      3'd3:    g = tab[27 +: GAIN_PT_W];
      3'd4:    g = tab[36 +: GAIN_PT_W];
      3'd5:    g = tab[45 +: GAIN_PT_W];
      3'd6:    g = tab[54 +: GAIN_PT_W];
      default: g = tab[0  +: GAIN_PT_W];
    endcase
    return g;
  endfunction

endpackage

@@ src/fgti_cfg.sv @@
// ----------------------------------------------------------------------------
// fgti_cfg
// Configuration register file: scales, four rule tables, two gain tables.
// ----------------------------------------------------------------------------
module fgti_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fgti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgti_pkg::CFG_DATA_W-1:0] cfg_data,
  output fgti_pkg::cfg_t                cfg
);
  import fgti_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIST_SCALE: cfg_nxt.dist_scale  = cfg_data[SCALE_W-1:0];
        CFG_ERR_SCALE:  cfg_nxt.err_scale   = cfg_data[SCALE_W-1:0];
        CFG_RULE_ZERO:  cfg_nxt.rule_tab[0] = cfg_data[RULE_W-1:0];
        CFG_RULE_ONE:   cfg_nxt.rule_tab[1] = cfg_data[RULE_W-1:0];
        CFG_RULE_TWO:   cfg_nxt.rule_tab[2] = cfg_data[RULE_W-1:0];
        CFG_RULE_THREE: cfg_nxt.rule_tab[3] = cfg_data[RULE_W-1:0];
        CFG_GAIN_LEFT:  cfg_nxt.gain_left   = cfg_data[GAIN_TAB_W-1:0];
        CFG_GAIN_RIGHT: cfg_nxt.gain_right  = cfg_data[GAIN_TAB_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dist_scale <= DIST_SCALE_RST;
      cfg_r.err_scale  <= ERR_SCALE_RST;
      cfg_r.rule_tab   <= '0;
      cfg_r.gain_left  <= '0;
      cfg_r.gain_right <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/fgti_front.sv @@
// ----------------------------------------------------------------------------
// fgti_front
// Stage 1 forms magnitudes and scale products; stage 2 turns them into
// saturated coordinates and fetches the four surrounding rule levels.
// ----------------------------------------------------------------------------
module fgti_front #(
  parameter int COORD_FRAC_BITS = fgti_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en_s1,
  input  logic                              en_s2,
  input  logic signed [fgti_pkg::IN_W-1:0]  view_distance,
  input  logic signed [fgti_pkg::IN_W-1:0]  center_error,
  input  logic [fgti_pkg::SEL_W-1:0]        table_select,
  input  fgti_pkg::cfg_t                    cfg,
  output logic [3:0][fgti_pkg::RULE_LVL_W-1:0] rules,
  output logic [COORD_FRAC_BITS-1:0]        frac_h,
  output logic [COORD_FRAC_BITS-1:0]        frac_v,
  output logic                              neg
);
  import fgti_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int CW    = F + 2;
  localparam int PW    = 2 * IN_W;
  localparam int SHIFT = 16 - F;
  localparam logic [PW-1:0] LIM = PW'(3) << F;

  // stage 1
  logic signed [IN_W:0] vd_off;
  logic signed [IN_W:0] ce_neg;
  logic [IN_W-1:0]      mag_d;
  logic [IN_W-1:0]      mag_e;
  logic [PW-1:0]        prod_d_r, prod_e_r;
  logic [SEL_W-1:0]     tsel_r;
  logic                 neg1_r;

  always_comb begin
    vd_off = {view_distance[IN_W-1], view_distance} - (IN_W+1)'(2);
    mag_d  = vd_off[IN_W] ? '0 : vd_off[IN_W-1:0];
    ce_neg = -{center_error[IN_W-1], center_error};
    mag_e  = center_error[IN_W-1] ? ce_neg[IN_W-1:0] : center_error;
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      prod_d_r <= PW'(mag_d) * PW'(cfg.dist_scale);
      prod_e_r <= PW'(mag_e) * PW'(cfg.err_scale);
      tsel_r   <= table_select;
      neg1_r   <= center_error[IN_W-1];
    end
  end

  // stage 2
  logic [PW-1:0]        sh_d, sh_e;
  logic [CW-1:0]        coord_h, coord_v;
  logic [1:0]           h1, h2, e1, e2;
  logic [RULE_W-1:0]    tab;
  logic [3:0][RULE_LVL_W-1:0] rules_r, rules_nxt;
  logic [F-1:0]         fh_r, fv_r;
  logic                 neg2_r;

  always_comb begin
    sh_d    = prod_d_r >> SHIFT;
    sh_e    = prod_e_r >> SHIFT;
    coord_h = (sh_d > LIM) ? LIM[CW-1:0] : sh_d[CW-1:0];
    coord_v = (sh_e > LIM) ? LIM[CW-1:0] : sh_e[CW-1:0];
    h1      = coord_h[CW-1:F];
    e1      = coord_v[CW-1:F];
    h2      = (h1 == 2'd3) ? 2'd3 : h1 + 2'd1;
    e2      = (e1 == 2'd3) ? 2'd3 : e1 + 2'd1;
    tab     = cfg.rule_tab[tsel_r];
    rules_nxt[0] = rule_at(tab, h1, e1);
    rules_nxt[1] = rule_at(tab, h1, e2);
    rules_nxt[2] = rule_at(tab, h2, e1);
    rules_nxt[3] = rule_at(tab, h2, e2);
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      rules_r <= rules_nxt;
      fh_r    <= coord_h[F-1:0];
      fv_r    <= coord_v[F-1:0];
      neg2_r  <= neg1_r;
    end
  end

  assign rules  = rules_r;
  assign frac_h = fh_r;
  assign frac_v = fv_r;
  assign neg    = neg2_r;

endmodule

@@ src/fgti_level.sv @@
// ----------------------------------------------------------------------------
// fgti_level
// Stage 3: four one-axis interpolations over the rule levels, averaged and
// saturated at 6.0.
// ----------------------------------------------------------------------------
module fgti_level #(
  parameter int COORD_FRAC_BITS = fgti_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [3:0][fgti_pkg::RULE_LVL_W-1:0] rules,
  input  logic [COORD_FRAC_BITS-1:0]           frac_h,
  input  logic [COORD_FRAC_BITS-1:0]           frac_v,
  input  logic                                 neg_in,
  output logic [COORD_FRAC_BITS+2:0]           level,
  output logic                                 neg
);
  import fgti_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int TW = F + 5;
  localparam int SW = F + 6;
  localparam int LW = F + 3;
  localparam logic [LW-1:0] LVL_MAX = LW'(6) << F;

  // lo * 2^F + (hi - lo) * f, exact
  function automatic logic signed [TW-1:0] lerp(input logic [RULE_LVL_W-1:0] lo,
                                                input logic [RULE_LVL_W-1:0] hi,
                                                input logic [F-1:0] f);
    logic signed [TW-1:0] diff;
    logic signed [TW-1:0] base;
    diff = TW'(signed'({1'b0, hi})) - TW'(signed'({1'b0, lo}));
    base = signed'(TW'({lo, {F{1'b0}}}));
    return base + diff * signed'(TW'(f));
  endfunction

  logic signed [TW-1:0] ia, ib, ic, id;
  logic signed [SW-1:0] sum;
  logic [LW-1:0]        avg;
  logic [LW-1:0]        level_r;
  logic                 neg_r;

  always_comb begin
    ia  = lerp(rules[0], rules[1], frac_v);
    ib  = lerp(rules[2], rules[3], frac_v);
    ic  = lerp(rules[0], rules[2], frac_h);
    id  = lerp(rules[1], rules[3], frac_h);
    sum = SW'(ia) + SW'(ib) + SW'(ic) + SW'(id);
    avg = sum[LW+1:2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r <= (avg > LVL_MAX) ? LVL_MAX : avg;
      neg_r   <= neg_in;
    end
  end

  assign level = level_r;
  assign neg   = neg_r;

endmodule

@@ src/fgti_gain.sv @@
// ----------------------------------------------------------------------------
// fgti_gain
// Stage 4 fetches the two neighboring gain points; stage 5 interpolates
// between them and holds the result for the output channel.
// ----------------------------------------------------------------------------
module fgti_gain #(
  parameter int COORD_FRAC_BITS = fgti_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en_s4,
  input  logic                          en_s5,
  input  logic [COORD_FRAC_BITS+2:0]    level,
  input  logic                          neg,
  input  fgti_pkg::cfg_t                cfg,
  output logic [fgti_pkg::GAIN_W-1:0]   gain
);
  import fgti_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int AW  = F + GAIN_PT_W + 2;
  localparam int OSH = GAIN_FRAC + F - OUT_FRAC;

  // stage 4
  logic [2:0]            p1, p2;
  logic [GAIN_TAB_W-1:0] gtab;
  logic [GAIN_PT_W-1:0]  g1_r, g2_r;
  logic [F-1:0]          fl_r;

  always_comb begin
    p1   = level[F+2:F];
    p2   = (p1 >= 3'd6) ? 3'd6 : p1 + 3'd1;
    gtab = neg ? cfg.gain_left : cfg.gain_right;
  end

  always_ff @(posedge clk) begin
    if (en_s4) begin
      g1_r <= gain_at(gtab, p1);
      g2_r <= gain_at(gtab, p2);
      fl_r <= level[F-1:0];
    end
  end

  // stage 5
  logic signed [AW-1:0]  gdiff;
  logic signed [AW-1:0]  acc;
  logic [GAIN_W-1:0]     gain_r;

  always_comb begin
    gdiff = AW'(signed'({1'b0, g2_r})) - AW'(signed'({1'b0, g1_r}));
    acc   = signed'(AW'({g1_r, {F{1'b0}}})) + gdiff * signed'(AW'(fl_r));
  end

  always_ff @(posedge clk) begin
    if (en_s5) begin
      gain_r <= acc[OSH +: GAIN_W];
    end
  end

  assign gain = gain_r;

endmodule

@@ src/fuzzy_gain_table_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// fuzzy_gain_table_interpolator_top
// Fuzzy gain scheduling: distance and error coordinates, rule table
// interpolation, then gain table interpolation, in a five stage pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | view_distance, center_error, table_select
//  out_    | output    | out_valid / out_ready | gain
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Throughput one item per clock while the output is not stalled. Five register
//  stages (products, coordinates and rule fetch, level, gain fetch, gain
//  interpolation): out_valid rises once an item reaches the last stage.
//  rst_n is synchronous: it empties the pipeline and loads the register
//  defaults. cfg_ready is always high. With out_ready low, bubbles are squeezed
//  out and in_ready drops only when every stage holds an item.
// ----------------------------------------------------------------------------
module fuzzy_gain_table_interpolator_top #(
  parameter int COORD_FRAC_BITS = fgti_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fgti_pkg::IN_W-1:0]    in_view_distance,
  input  logic signed [fgti_pkg::IN_W-1:0]    in_center_error,
  input  logic [fgti_pkg::SEL_W-1:0]          in_table_select,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fgti_pkg::GAIN_W-1:0]         out_gain,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fgti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fgti_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fgti_pkg::*;

  localparam int F       = COORD_FRAC_BITS;
  localparam int NSTAGES = 5;

  cfg_t                          cfg;
  logic [NSTAGES-1:0]            valid_r, valid_nxt;
  logic [NSTAGES-1:0]            en;
  logic [3:0][RULE_LVL_W-1:0]    rules;
  logic [F-1:0]                  frac_h, frac_v;
  logic                          neg_2, neg_3;
  logic [F+2:0]                  level;

  // A stage takes a new item when it is empty or its content moves on.
  always_comb begin
    en[NSTAGES-1] = !valid_r[NSTAGES-1] || out_ready;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int i = 1; i < NSTAGES; i++) begin
      valid_nxt[i] = en[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid_r[NSTAGES-1];

  fgti_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fgti_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk           (clk),
    .en_s1         (en[0]),
    .en_s2         (en[1]),
    .view_distance (in_view_distance),
    .center_error  (in_center_error),
    .table_select  (in_table_select),
    .cfg           (cfg),
    .rules         (rules),
    .frac_h        (frac_h),
    .frac_v        (frac_v),
    .neg           (neg_2)
  );

  fgti_level #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_level (
    .clk    (clk),
    .en     (en[2]),
    .rules  (rules),
    .frac_h (frac_h),
    .frac_v (frac_v),
    .neg_in (neg_2),
    .level  (level),
    .neg    (neg_3)
  );

  fgti_gain #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_gain (
    .clk   (clk),
    .en_s4 (en[3]),
    .en_s5 (en[4]),
    .level (level),
    .neg   (neg_3),
    .cfg   (cfg),
    .gain  (out_gain)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fuzzy gain table interpolator: random and
// directed items on a valid/ready input, gains checked in order against a
// bit-exact predictor, register sets reloaded between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import fgti_pkg::*;

  localparam int DRAIN      = 8;
  localparam int LONG_HOLD  = 300;
  localparam int LIMIT      = 3000;
  localparam int RAND_ITEMS = 216;
  localparam int N_PHASES   = 8;

  class gain_scoreboard;
    logic [SCALE_W-1:0]    dist_scale;
    logic [SCALE_W-1:0]    err_scale;
    logic [RULE_W-1:0]     rule_tab [N_TABLES];
    logic [GAIN_TAB_W-1:0] gain_left;
    logic [GAIN_TAB_W-1:0] gain_right;
    logic [GAIN_W-1:0]     expected_gains [$];
    int                    mismatches;

    function new();
      dist_scale = DIST_SCALE_RST;
      err_scale  = ERR_SCALE_RST;
      foreach (rule_tab[i]) rule_tab[i] = '0;
      gain_left  = '0;
      gain_right = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DIST_SCALE: dist_scale  = data[SCALE_W-1:0];
        CFG_ERR_SCALE:  err_scale   = data[SCALE_W-1:0];
        CFG_RULE_ZERO:  rule_tab[0] = data[RULE_W-1:0];
        CFG_RULE_ONE:   rule_tab[1] = data[RULE_W-1:0];
        CFG_RULE_TWO:   rule_tab[2] = data[RULE_W-1:0];
        CFG_RULE_THREE: rule_tab[3] = data[RULE_W-1:0];
        CFG_GAIN_LEFT:  gain_left   = data[GAIN_TAB_W-1:0];
        CFG_GAIN_RIGHT: gain_right  = data[GAIN_TAB_W-1:0];
        default: ;
      endcase
    endfunction

    // Scaled coordinate, saturated at 3.0
    function longint coord(longint mag, logic [SCALE_W-1:0] scale);
      longint prod;
      prod = (mag * longint'(scale)) >>> (SCALE_W - COORD_FRAC_BITS_DEF);
      if (prod > (longint'(3) << COORD_FRAC_BITS_DEF))
        prod = longint'(3) << COORD_FRAC_BITS_DEF;
      return prod;
    endfunction

    function longint level_of(logic [RULE_W-1:0] tab, int r, int c);
      return longint'(tab[3 * (r * 4 + c) +: RULE_LVL_W]);
    endfunction

    function logic [GAIN_W-1:0] predict_gain(logic signed [IN_W-1:0] vd,
                                             logic signed [IN_W-1:0] ce,
                                             logic [SEL_W-1:0] sel);
      longint one, dist_off, mag, ch, cv, fh, fv;
      longint r11, r12, r21, r22, a, b, c, d, level, fl, g1, g2, acc;
      int h1, h2, e1, e2, p1, p2;
      logic [RULE_W-1:0] tab;
      logic [GAIN_TAB_W-1:0] gtab;
      one  = longint'(1) << COORD_FRAC_BITS_DEF;
      dist_off = longint'(vd) - 2;
      if (dist_off < 0) dist_off = 0;
      mag  = longint'(ce);
      if (mag < 0) mag = -mag;
      ch = coord(dist_off, dist_scale);
      cv = coord(mag, err_scale);
      h1 = int'(ch >>> COORD_FRAC_BITS_DEF);
      fh = ch & (one - 1);
      h2 = (h1 + 1 > 3) ? 3 : h1 + 1;
      e1 = int'(cv >>> COORD_FRAC_BITS_DEF);
      fv = cv & (one - 1);
      e2 = (e1 + 1 > 3) ? 3 : e1 + 1;
      tab = rule_tab[sel];
      r11 = level_of(tab, h1, e1);
      r12 = level_of(tab, h1, e2);
      r21 = level_of(tab, h2, e1);
      r22 = level_of(tab, h2, e2);
      // two blends along the error axis, two along the distance axis
      a = r11 * one + (r12 - r11) * fv;
      b = r21 * one + (r22 - r21) * fv;
      c = r11 * one + (r21 - r11) * fh;
      d = r12 * one + (r22 - r12) * fh;
      level = (a + b + c + d) >>> 2;
      if (level > 6 * one) level = 6 * one;
      p1 = int'(level >>> COORD_FRAC_BITS_DEF);
      fl = level & (one - 1);
      p2 = (p1 + 1 > 6) ? 6 : p1 + 1;
      gtab = (ce < 0) ? gain_left : gain_right;
      g1 = longint'(gtab[GAIN_PT_W * p1 +: GAIN_PT_W]);
      g2 = longint'(gtab[GAIN_PT_W * p2 +: GAIN_PT_W]);
      acc = g1 * one + (g2 - g1) * fl;
      acc = acc >>> (GAIN_FRAC + COORD_FRAC_BITS_DEF - OUT_FRAC);
      return GAIN_W'(acc);
    endfunction

    function void note_item(logic signed [IN_W-1:0] vd, logic signed [IN_W-1:0] ce,
                            logic [SEL_W-1:0] sel);
      expected_gains.push_back(predict_gain(vd, ce, sel));
    endfunction

    function void check_gain(logic [GAIN_W-1:0] gain);
      logic [GAIN_W-1:0] want;
      if (expected_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("gain %0d arrived with no item pending", gain);
        return;
      end
      want = expected_gains.pop_front();
      if (gain !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("gain mismatch: expected %0d, actual %0d", want, gain);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [IN_W-1:0]       in_view_distance;
  logic signed [IN_W-1:0]       in_center_error;
  logic [SEL_W-1:0]             in_table_select;
  logic                         out_valid;
  logic                         out_ready;
  logic [GAIN_W-1:0]            out_gain;
  logic                         cfg_valid;
  logic                         cfg_ready;
  cfg_idx_t                     cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  gain_scoreboard               board;
  logic [CFG_DATA_W-1:0]        cfg_words [8];
  int                           send_left;
  bit                           send_calm;
  int                           recv_left;
  bit                           recv_calm;
  bit                           hold_output;

  fuzzy_gain_table_interpolator_top #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS_DEF)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_view_distance (in_view_distance),
    .in_center_error  (in_center_error),
    .in_table_select  (in_table_select),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_gain         (out_gain),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stretches of back-to-back items alternate with random gaps
  task automatic draw_gap(inout int left, inout bit calm, output int gap);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    gap = calm ? 0 : $urandom_range(0, 8);
  endtask

  task automatic send_item(logic signed [IN_W-1:0] vd, logic signed [IN_W-1:0] ce,
                           logic [SEL_W-1:0] sel);
    int gap;
    draw_gap(send_left, send_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_view_distance <= vd;
    in_center_error  <= ce;
    in_table_select  <= sel;
    do @(posedge clk); while (!in_ready);
    board.note_item(vd, ce, sel);
  endtask

  task automatic load_config();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= cfg_words[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(cfg_idx_t'(i), cfg_words[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drop the input, then wait until every expected gain has come
  task automatic wait_results();
    in_valid <= 1'b0;
    while (board.expected_gains.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale(logic [SCALE_W-1:0] typical);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 16'd1;
      3:       return typical;
      default: return SCALE_W'($urandom_range(512, 16384));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_table();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return CFG_DATA_W'({$urandom, $urandom});
    endcase
  endfunction

  // Magnitude mostly within the span where the coordinate is below 3.0
  function automatic int pick_mag(logic [SCALE_W-1:0] scale);
    int span;
    span = (3 << 16) / ((scale == 0) ? 1 : int'(scale)) + 8;
    if (span > 32767) span = 32767;
    return $urandom_range(0, span);
  endfunction

  task automatic send_random_item();
    int dist_mag;
    int err_mag;
    logic signed [IN_W-1:0] vd;
    logic signed [IN_W-1:0] ce;
    dist_mag = pick_mag(board.dist_scale);
    err_mag  = pick_mag(board.err_scale);
    if ($urandom_range(0, 4) == 0) begin
      vd = IN_W'($urandom);
      ce = IN_W'($urandom);
    end else begin
      vd = IN_W'((dist_mag > 32765) ? 32767 : dist_mag + 2);
      ce = IN_W'(err_mag);
      if ($urandom_range(0, 1) == 1) ce = -ce;
    end
    send_item(vd, ce, SEL_W'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      draw_gap(recv_left, recv_calm, gap);
      if (hold_output) begin
        hold_output = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_gain(out_gain);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    board            = new();
    send_left        = 0;
    send_calm        = 1'b0;
    recv_left        = 0;
    recv_calm        = 1'b0;
    hold_output      = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_view_distance = '0;
    in_center_error  = '0;
    in_table_select  = '0;
    out_ready        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_DIST_SCALE;
    cfg_data         = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: gain tables are all zero
    send_item(0, 0, 0);
    send_item(30, -10, 1);
    send_item(-32768, -32768, 3);
    wait_idle();

    for (int i = 0; i < 8; i++) cfg_words[i] = CFG_DATA_W'({$urandom, $urandom});
    cfg_words[CFG_DIST_SCALE] = CFG_DATA_W'(DIST_SCALE_RST);
    cfg_words[CFG_ERR_SCALE]  = CFG_DATA_W'(ERR_SCALE_RST);
    cfg_words[CFG_RULE_THREE] = '1;
    load_config();
    send_item(-32768, 0, 0);
    send_item(1, 1, 0);
    send_item(2, -1, 1);
    send_item(3, -32768, 2);
    send_item(32767, 32767, 3);
    send_item(24, 15, 0);
    send_item(47, -15, 1);
    send_item(12, 7, 2);
    send_item(20, -29, 3);     // all-seven table drives the level past six
    send_item(45, 30, 3);
    send_item(-1, -32768, 1);
    wait_idle();

    // Zero scales pin both coordinates at the origin
    cfg_words[CFG_DIST_SCALE] = '0;
    cfg_words[CFG_ERR_SCALE]  = '0;
    load_config();
    send_item(100, -200, 0);
    send_item(32767, 32767, 3);
    wait_idle();

    cfg_words[CFG_DIST_SCALE] = CFG_DATA_W'(16'hFFFF);
    cfg_words[CFG_ERR_SCALE]  = CFG_DATA_W'(16'hFFFF);
    load_config();
    send_item(3, 1, 0);
    send_item(-5, -2, 2);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      for (int i = 0; i < 8; i++) cfg_words[i] = pick_table();
      cfg_words[CFG_DIST_SCALE] = CFG_DATA_W'({$urandom, $urandom});
      cfg_words[CFG_ERR_SCALE]  = CFG_DATA_W'({$urandom, $urandom});
      case (phase)
        0: begin
          cfg_words[CFG_DIST_SCALE][SCALE_W-1:0] = '0;
          cfg_words[CFG_ERR_SCALE][SCALE_W-1:0]  = '1;
        end
        1: begin
          cfg_words[CFG_DIST_SCALE][SCALE_W-1:0] = '1;
          cfg_words[CFG_ERR_SCALE][SCALE_W-1:0]  = '0;
        end
        default: begin
          cfg_words[CFG_DIST_SCALE][SCALE_W-1:0] = pick_scale(DIST_SCALE_RST);
          cfg_words[CFG_ERR_SCALE][SCALE_W-1:0]  = pick_scale(ERR_SCALE_RST);
        end
      endcase
      load_config();
      // stall the output long enough for the pipeline to back up
      if (phase == 2) hold_output = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (phase == 4 && n == RAND_ITEMS / 2) wait_results();
        send_random_item();
      end
    end
    wait_idle();

    if (board.mismatches == 0 && board.expected_gains.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
